// File: hw/rtl/deq_pkg.sv
`timescale 1ns / 1ps

package deq_pkg;

    // storage shape
    localparam int DEPTH      = 1024;
    localparam int WORD_BITS  = 32;
    localparam int IO_BITS    = 32;
    localparam int COUNT_BITS = $clog2(DEPTH + 1);
    localparam int CMD_BITS   = 3;

    // back-select tree: leaves per group and number of groups
    localparam int GROUP      = 32;
    localparam int NUM_GROUPS = (DEPTH + GROUP - 1) / GROUP;

    // common width for word conversions
    localparam int WIDE_BITS  = (WORD_BITS > IO_BITS) ? WORD_BITS : IO_BITS;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_QUERY      = 3'd4
    } t_cmd;

    // what every cell of the row does on a clock edge
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_SHIFT_IN_FRONT,
        OP_LOAD_BACK,
        OP_SHIFT_OUT_FRONT,
        OP_DROP_BACK
    } t_cell_op;

    typedef struct packed {
        t_cell_op               op;
        logic [WORD_BITS-1:0]   word;
    } t_cell_ctl;

    // port word into stored word (zero extend or truncate)
    function automatic logic [WORD_BITS-1:0] from_io(logic [IO_BITS-1:0] w);
        logic [WIDE_BITS-1:0] t;
        t = WIDE_BITS'(w);
        return t[WORD_BITS-1:0];
    endfunction

    // stored word into port word (zero extend or truncate)
    function automatic logic [IO_BITS-1:0] to_io(logic [WORD_BITS-1:0] w);
        logic [WIDE_BITS-1:0] t;
        t = WIDE_BITS'(w);
        return t[IO_BITS-1:0];
    endfunction

endpackage

// File: hw/rtl/deq_cell.sv
`timescale 1ns / 1ps

module deq_cell
    import deq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cell_ctl            i_ctl,
    input  logic [WORD_BITS-1:0] i_left_data,
    input  logic                 i_left_last,
    input  logic [WORD_BITS-1:0] i_right_data,
    input  logic                 i_right_last,
    output logic [WORD_BITS-1:0] o_data,
    output logic                 o_last
);

    logic [WORD_BITS-1:0] r_data;
    logic                 r_last;

    // element word: moves with the front end, or takes a new back word
    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            OP_SHIFT_IN_FRONT:  r_data <= i_left_data;
            OP_LOAD_BACK: begin
                if (i_left_last) begin
                    r_data <= i_ctl.word;
                end
            end
            OP_SHIFT_OUT_FRONT: r_data <= i_right_data;
            default:            r_data <= r_data;
        endcase
    end

    // last-element marker walks one cell per push or pop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= 1'b0;
        end else begin
            case (i_ctl.op)
                OP_SHIFT_IN_FRONT,
                OP_LOAD_BACK:       r_last <= i_left_last;
                OP_SHIFT_OUT_FRONT,
                OP_DROP_BACK:       r_last <= i_right_last;
                default:            r_last <= r_last;
            endcase
        end
    end

    assign o_data = r_data;
    assign o_last = r_last;

endmodule

// File: hw/rtl/deq_back_sel.sv
`timescale 1ns / 1ps

module deq_back_sel
    import deq_pkg::*;
(
    input  logic                 i_clk,
    input  logic [WORD_BITS-1:0] i_data [DEPTH],
    input  logic                 i_last [DEPTH],
    input  logic                 i_grp_load,
    input  logic                 i_fin_load,
    output logic [WORD_BITS-1:0] o_back
);

    logic [WORD_BITS-1:0] w_grp [NUM_GROUPS];
    logic [WORD_BITS-1:0] r_grp [NUM_GROUPS];
    logic [WORD_BITS-1:0] w_fin;
    logic [WORD_BITS-1:0] r_back;

    // first level: or of the marked word inside each group of cells
    for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_grp
        always_comb begin
            w_grp[g] = '0;
            for (int k = 0; k < GROUP; k++) begin
                if (g * GROUP + k < DEPTH) begin
                    w_grp[g] = w_grp[g]
                        | (i_data[g * GROUP + k] & {WORD_BITS{i_last[g * GROUP + k]}});
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_grp_load) begin
                r_grp[g] <= w_grp[g];
            end
        end
    end

    // second level: or across groups
    always_comb begin
        w_fin = '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            w_fin = w_fin | r_grp[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fin_load) begin
            r_back <= w_fin;
        end
    end

    assign o_back = r_back;

endmodule

// File: hw/rtl/double_ended_queue.sv
`timescale 1ns / 1ps

// Bounded deque of DEPTH signed words, held in a row of cells with the front element
// in the first cell. For every transaction (push front/back, pop front/back, query),
// the row updates at the accepting edge, then a two-level registered OR tree
// finds the word in the cell that carries the last-element marker. busy is high
// while the two tree levels load (r_s1, r_s2), and o_strobe marks the result for
// one cycle once the result registers have loaded; no new transaction is accepted
// until busy drops. The receiver cannot stall: the result must be taken while
// o_strobe is high. Pops on an empty deque and pushes onto a full one leave the
// contents unchanged; the latter raise o_overflow. No clearing pass follows reset.

module double_ended_queue
    import deq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [CMD_BITS-1:0]   i_cmd,
    input  logic signed [IO_BITS-1:0] i_push_value,
    output logic                  o_strobe,
    output logic signed [IO_BITS-1:0] o_pop_value,
    output logic                  o_pop_valid,
    output logic [COUNT_BITS-1:0] o_count,
    output logic                  o_is_empty,
    output logic signed [IO_BITS-1:0] o_front_value,
    output logic signed [IO_BITS-1:0] o_back_value,
    output logic                  o_overflow
);

    logic                  w_accept;
    logic                  w_full;
    logic                  w_empty;
    t_cell_ctl             w_ctl;
    logic [COUNT_BITS-1:0] n_count;
    logic                  n_pop_valid;
    logic                  n_overflow;
    logic [WORD_BITS-1:0]  n_pop_word;

    logic [COUNT_BITS-1:0] r_count;
    logic                  r_s1;
    logic                  r_s2;
    logic                  r_pop_valid;
    logic                  r_overflow;
    logic [WORD_BITS-1:0]  r_pop_word;

    logic                  r_out_valid;
    logic [IO_BITS-1:0]    r_out_pop_value;
    logic                  r_out_pop_valid;
    logic [COUNT_BITS-1:0] r_out_count;
    logic                  r_out_is_empty;
    logic [IO_BITS-1:0]    r_out_front;
    logic                  r_out_overflow;

    logic [WORD_BITS-1:0]  w_data [DEPTH];
    logic                  w_last [DEPTH];
    logic [DEPTH-1:0]      w_last_vec;
    logic [WORD_BITS-1:0]  w_back;

    assign w_accept = start && !busy;
    assign w_full   = (r_count == COUNT_BITS'(DEPTH));
    assign w_empty  = (r_count == '0);

    // command decode into one row operation
    always_comb begin
        w_ctl.op    = OP_HOLD;
        w_ctl.word  = from_io(i_push_value);
        n_count     = r_count;
        n_pop_valid = 1'b0;
        n_overflow  = 1'b0;
        n_pop_word  = w_data[0];
        if (w_accept) begin
            unique case (t_cmd'(i_cmd))
                CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                    if (w_full) begin
                        n_overflow = 1'b1;
                    end else begin
                        w_ctl.op = (t_cmd'(i_cmd) == CMD_PUSH_FRONT) ?
                                   OP_SHIFT_IN_FRONT : OP_LOAD_BACK;
                        n_count  = r_count + 1'b1;
                    end
                end
                CMD_POP_FRONT, CMD_POP_BACK: begin
                    if (!w_empty) begin
                        if (t_cmd'(i_cmd) == CMD_POP_FRONT) begin
                            w_ctl.op   = OP_SHIFT_OUT_FRONT;
                            n_pop_word = w_data[0];
                        end else begin
                            w_ctl.op   = OP_DROP_BACK;
                            n_pop_word = w_back;
                        end
                        n_count     = r_count - 1'b1;
                        n_pop_valid = 1'b1;
                    end
                end
                default: begin
                    w_ctl.op = OP_HOLD;
                end
            endcase
        end
    end

    // row of cells, front element in cell 0
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [WORD_BITS-1:0] w_ldata;
        logic                 w_llast;
        logic [WORD_BITS-1:0] w_rdata;
        logic                 w_rlast;

        if (i == 0) begin : g_first
            assign w_ldata = w_ctl.word;
            assign w_llast = w_empty;
        end else begin : g_mid_l
            assign w_ldata = w_data[i-1];
            assign w_llast = w_last[i-1];
        end

        if (i == DEPTH - 1) begin : g_end
            assign w_rdata = '0;
            assign w_rlast = 1'b0;
        end else begin : g_mid_r
            assign w_rdata = w_data[i+1];
            assign w_rlast = w_last[i+1];
        end

        deq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_left_data  (w_ldata),
            .i_left_last  (w_llast),
            .i_right_data (w_rdata),
            .i_right_last (w_rlast),
            .o_data       (w_data[i]),
            .o_last       (w_last[i])
        );

        assign w_last_vec[i] = w_last[i];
    end

    // back word lookup, two registered levels
    deq_back_sel u_back_sel (
        .i_clk      (i_clk),
        .i_data     (w_data),
        .i_last     (w_last),
        .i_grp_load (r_s1),
        .i_fin_load (r_s2),
        .o_back     (w_back)
    );

    // sequencing and element count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_s1        <= 1'b0;
            r_s2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_s1        <= w_accept;
            r_s2        <= r_s1;
            r_out_valid <= r_s2;
        end
    end

    // per-transaction flags held until the result stage
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pop_valid <= n_pop_valid;
            r_overflow  <= n_overflow;
            r_pop_word  <= n_pop_word;
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (r_s2) begin
            r_out_pop_value <= r_pop_valid ? to_io(r_pop_word) : '1;
            r_out_pop_valid <= r_pop_valid;
            r_out_count     <= r_count;
            r_out_is_empty  <= w_empty;
            r_out_front     <= w_empty ? '1 : to_io(w_data[0]);
            r_out_overflow  <= r_overflow;
        end
    end

    assign busy          = r_s1 || r_s2;
    assign o_strobe      = r_out_valid;
    assign o_pop_value   = r_out_pop_value;
    assign o_pop_valid   = r_out_pop_valid;
    assign o_count       = r_out_count;
    assign o_is_empty    = r_out_is_empty;
    assign o_front_value = r_out_front;
    assign o_back_value  = r_out_is_empty ? '1 : to_io(w_back);
    assign o_overflow    = r_out_overflow;

    // checks
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##3 o_strobe)
        else $error("result strobe missing three cycles after accept");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_BITS'(DEPTH))
        else $error("element count beyond depth");

    a_marker_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> $onehot(w_last_vec))
        else $error("last-element marker not unique");

    a_marker_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (w_last_vec == '0))
        else $error("marker present in empty deque");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !(o_pop_valid && o_overflow))
        else $error("pop and overflow in one transaction");

endmodule
